// ===== sv/b64d_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream decoder
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

   localparam int CHAR_W   = 8;
   localparam int SEXTET_W = 6;
   localparam int PHASE_W  = 2;

   localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;

   localparam logic [CHAR_W-1:0]   LOWER_BASE = 8'd26;
   localparam logic [CHAR_W-1:0]   DIGIT_BASE = 8'd52;
   localparam logic [SEXTET_W-1:0] PLUS_CODE  = 6'd62;
   localparam logic [SEXTET_W-1:0] SLASH_CODE = 6'd63;

   localparam logic [PHASE_W-1:0] PHASE_EMPTY = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_ONE   = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_TWO   = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_THREE = 2'd3;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] in_char;
      logic              is_end;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] out_byte;
      kind_type          kind;
   } result_type;

   typedef struct packed {
      logic                invalid;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] c);
      sextet_type r;
      r.invalid = 1'b0;
      r.value   = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r.value = SEXTET_W'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r.value = SEXTET_W'(c - CHAR_LOWER_A + LOWER_BASE);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         r.value = SEXTET_W'(c - CHAR_DIGIT_0 + DIGIT_BASE);
      end else if (c == CHAR_PLUS) begin
         r.value = PLUS_CODE;
      end else if (c == CHAR_SLASH) begin
         r.value = SLASH_CODE;
      end else begin
         r.invalid = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_in_stage.sv =====
// input register for incoming character transactions
`timescale 1ns / 1ps
`default_nettype none

module b64d_in_stage (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [b64d_pkg::CHAR_W-1:0] req_char,
   input  wire logic                        req_is_end,
   input  wire logic                        advance,
   output b64d_pkg::item_type               item
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [b64d_pkg::CHAR_W-1:0] char_ff;
   logic                        is_end_ff;
   logic                        take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff   <= req_char;
         is_end_ff <= req_is_end;
      end
   end

   assign item.valid   = valid_ff;
   assign item.in_char = char_ff;
   assign item.is_end  = is_end_ff;

endmodule

`default_nettype wire

// ===== sv/b64d_decode.sv =====
// quartet state, padding checks, byte assembly and end status for one character per cycle while advance is high
`timescale 1ns / 1ps
`default_nettype none

module b64d_decode (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data,
   input  wire b64d_pkg::item_type item,
   input  wire logic         advance,
   output b64d_pkg::result_type result
);

   logic                          skip_garbage_ff;
   logic [b64d_pkg::PHASE_W-1:0]  phase_ff;
   logic [b64d_pkg::PHASE_W-1:0]  phase_in;
   logic [b64d_pkg::SEXTET_W-1:0] prev_ff;
   logic [b64d_pkg::SEXTET_W-1:0] prev_in;
   logic                          want_pad_ff;
   logic                          want_pad_in;
   logic                          error_ff;
   logic                          error_in;
   b64d_pkg::sextet_type          sx;
   logic                          emit;
   logic [b64d_pkg::CHAR_W-1:0]   byte_val;
   b64d_pkg::kind_type            kind;
   logic                          end_ok;

   assign sx     = b64d_pkg::sextet_of(item.in_char);
   assign end_ok = !error_ff && (phase_ff == b64d_pkg::PHASE_EMPTY) && !want_pad_ff;

   always_comb begin
      phase_in    = phase_ff;
      prev_in     = prev_ff;
      want_pad_in = want_pad_ff;
      error_in    = error_ff;
      emit        = 1'b0;
      byte_val    = '0;
      kind        = b64d_pkg::KIND_DATA;
      if (item.is_end) begin
         emit        = 1'b1;
         kind        = end_ok ? b64d_pkg::KIND_DONE : b64d_pkg::KIND_BAD;
         phase_in    = b64d_pkg::PHASE_EMPTY;
         prev_in     = '0;
         want_pad_in = 1'b0;
         error_in    = 1'b0;
      end else if (error_ff || item.in_char == b64d_pkg::CHAR_NEWLINE) begin
         emit = 1'b0;
      end else if (sx.invalid && item.in_char != b64d_pkg::CHAR_PAD) begin
         if (!skip_garbage_ff) begin
            error_in = 1'b1;
         end
      end else if (item.in_char == b64d_pkg::CHAR_PAD) begin
         if (want_pad_ff) begin
            want_pad_in = 1'b0;
            phase_in    = b64d_pkg::PHASE_EMPTY;
         end else if (phase_ff == b64d_pkg::PHASE_TWO) begin
            want_pad_in = 1'b1;
         end else if (phase_ff == b64d_pkg::PHASE_THREE) begin
            phase_in = b64d_pkg::PHASE_EMPTY;
         end else begin
            error_in = 1'b1;
         end
      end else if (want_pad_ff) begin
         error_in = 1'b1;
      end else begin
         prev_in = sx.value;
         case (phase_ff)
            b64d_pkg::PHASE_EMPTY: begin
               phase_in = b64d_pkg::PHASE_ONE;
            end
            b64d_pkg::PHASE_ONE: begin
               emit     = 1'b1;
               byte_val = {prev_ff, sx.value[5:4]};
               phase_in = b64d_pkg::PHASE_TWO;
            end
            b64d_pkg::PHASE_TWO: begin
               emit     = 1'b1;
               byte_val = {prev_ff[3:0], sx.value[5:2]};
               phase_in = b64d_pkg::PHASE_THREE;
            end
            default: begin
               emit     = 1'b1;
               byte_val = {prev_ff[1:0], sx.value};
               phase_in = b64d_pkg::PHASE_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_garbage_ff <= 1'b0;
      end else if (csr_wr_en) begin
         skip_garbage_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= b64d_pkg::PHASE_EMPTY;
         prev_ff     <= '0;
         want_pad_ff <= 1'b0;
         error_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         prev_ff     <= prev_in;
         want_pad_ff <= want_pad_in;
         error_ff    <= error_in;
      end
   end

   assign result.valid    = advance && emit;
   assign result.out_byte = byte_val;
   assign result.kind     = kind;

`ifndef SYNTHESIS
   a_pad_only_after_two : assert property (@(posedge clock) disable iff (reset)
      want_pad_ff |-> phase_ff == b64d_pkg::PHASE_TWO)
      else $error("second pad pending outside phase two");

   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      advance && item.is_end |=> phase_ff == b64d_pkg::PHASE_EMPTY && !error_ff && !want_pad_ff)
      else $error("end transaction did not clear stream state");

   a_data_needs_prev : assert property (@(posedge clock) disable iff (reset)
      result.valid && result.kind == b64d_pkg::KIND_DATA
      |-> phase_ff != b64d_pkg::PHASE_EMPTY && !error_ff)
      else $error("data byte without a previous sextet");
`endif

endmodule

`default_nettype wire

// ===== sv/b64d_out_stage.sv =====
// result register for outgoing byte and status transactions
`timescale 1ns / 1ps
`default_nettype none

module b64d_out_stage (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire b64d_pkg::result_type        result,
   output logic                             can_accept,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [b64d_pkg::CHAR_W-1:0]      rsp_byte,
   output logic [1:0]                       rsp_kind
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [b64d_pkg::CHAR_W-1:0] byte_ff;
   b64d_pkg::kind_type          kind_ff;

   assign can_accept = !valid_ff || rsp_tready;

   always_comb begin
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         byte_ff <= result.out_byte;
         kind_ff <= result.kind;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_kind   = kind_ff;

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// top level of the base64 stream decoder: input register, decode stage, result register
// throughput: one character per cycle when not stalled, set by the single decode stage
// a stalled result register holds the input stage and then the request side
// reset: synchronous active high, clears quartet state, error flag, skip_garbage and valids
// the user writes skip_garbage through csr_wr_en / csr_wr_data only while the decoder is
// idle; the decoder itself does not enforce this
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,  // skip_garbage
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] in_char
   input  wire logic [0:0] req_tuser,    // [0] is_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] out_byte
   output logic [1:0]      rsp_tuser     // [1:0] result_kind
);

   b64d_pkg::item_type   item;
   b64d_pkg::result_type result;
   logic                 can_accept;
   logic                 advance;

   assign advance = item.valid && can_accept;

   b64d_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .req_is_end (req_tuser[0]),
      .advance    (advance),
      .item       (item)
   );

   b64d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .advance     (advance),
      .result      (result)
   );

   b64d_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_kind   (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_stall_means_held : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> item.valid && rsp_tvalid && !rsp_tready)
      else $error("request side stalled without a held transaction");
`endif

endmodule

`default_nettype wire
